[rtl/gcd_pkg.sv]
package gcd_pkg;

	localparam int CORDIC_STEPS_DEF = 32;
	localparam int FRAC_BITS_DEF    = 30;

	// Stream payload widths.
	localparam int IN_W   = 136;
	localparam int OUT_W  = 32;
	localparam int DIST_W = 25;

	// Configuration register indexes.
	localparam logic [0:0] CFG_RADIUS  = 1'b0;
	localparam logic [0:0] CFG_MAX_AGE = 1'b1;

	localparam logic [15:0] AGE_RESET     = 16'd5000;
	localparam logic [24:0] RADIUS_RESET  = 25'd20902231;
	localparam logic [9:0]  M_PER_KFT_NUM = 10'd1000;
	localparam logic [11:0] M_PER_KFT_DEN = 12'd3281;
	localparam logic [34:0] RADIUS_K_RESET = 35'(RADIUS_RESET) * 35'(M_PER_KFT_NUM);

	localparam logic [63:0] PI_Q60       = 64'd3622009729038561421;
	localparam logic [63:0] INV_GAIN_Q60 = 64'd700114967507363240;
	localparam logic [38:0] RAD_K        = 39'd321956420359;

	// Square root stage: radicand is Q62, one result bit per step.
	localparam int ISQ_W     = 63;
	localparam int ISQ_STEPS = 32;
	localparam int ATAN_XW   = 35;

	// Scaled feet-times-thousand quotient and its reciprocal for the divide by 3281.
	localparam int Q_W     = 37;
	localparam int EST_W   = 26;
	localparam int RECIP_S = 48;
	localparam logic [36:0] RECIP_M = 37'((64'd1 << RECIP_S) / 64'd3281);

	// Restoring division, used only while building constant tables.
	function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
		logic [63:0] rem;
		logic [63:0] quo;
		rem = '0;
		quo = '0;
		for (int b = 63; b >= 0; b--) begin
			rem = {rem[62:0], n[b]};
			if (rem >= d) begin
				rem = rem - d;
				quo[b] = 1'b1;
			end
		end
		return quo;
	endfunction

	// Arctangent of 2^-i in Q60 by a truncated alternating series.
	function automatic logic [63:0] atan_q60(input int i);
		logic signed [63:0] sum;
		logic [63:0] term;
		int k;
		sum = '0;
		if (i == 0) begin
			sum = $signed(PI_Q60 >> 2);
		end else begin
			for (k = 0; i * (2 * k + 1) <= 60; k++) begin
				term = udiv64(64'd1 << (60 - i * (2 * k + 1)), 64'(2 * k + 1));
				if (k[0])
					sum = sum - $signed(term);
				else
					sum = sum + $signed(term);
			end
		end
		return sum;
	endfunction

endpackage

[rtl/great_circle_distance.sv]
// Haversine great-circle distance between a local and a remote position.
// The slave stream carries one pair of positions per beat, packed in s_tdata
// from the lowest bit up: local_lat, local_lon, local_fix_age_ms, remote_lat,
// remote_lon. The master stream returns one beat per input beat, in order:
// m_tuser is fix_status (1 means no usable fix), m_tdata holds distance_m.
// The two configuration registers (Earth radius in feet, oldest accepted fix
// age) are written through wr_en/wr_index/wr_data. The user must write them only
// while no beat is in flight; the block itself does not enforce it. Two CORDIC
// chains of CORDIC_STEPS stages (sin/cos and atan2) plus a 32-stage square root
// set the depth. One beat enters per cycle while the output is not stalled.
// The whole pipeline advances together; when the output beat is not taken,
// every stage holds and s_tready drops in the same cycle, so nothing is lost.
// Reset empties the pipeline and restores both registers to their defaults.
module great_circle_distance #(
	parameter int CORDIC_STEPS = gcd_pkg::CORDIC_STEPS_DEF,
	parameter int FRAC_BITS    = gcd_pkg::FRAC_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	// local_lat[27:0], local_lon[56:28], local_fix_age_ms[72:57],
	// remote_lat[100:73], remote_lon[129:101], zero padding above
	input  logic [gcd_pkg::IN_W-1:0]  s_tdata,
	output logic                      m_tvalid,
	input  logic                      m_tready,
	// distance_m[24:0], zero padding above
	output logic [gcd_pkg::OUT_W-1:0] m_tdata,
	// fix_status
	output logic                      m_tuser,
	input  logic                      wr_en,
	input  logic [0:0]                wr_index,
	input  logic [24:0]               wr_data
);

	localparam int W   = FRAC_BITS + 4;
	localparam int XW  = gcd_pkg::ATAN_XW;
	localparam int Z2W = FRAC_BITS + 2;
	localparam int NST = 2 * CORDIC_STEPS + 46;

	localparam logic signed [W-1:0] PI_F       = W'(gcd_pkg::PI_Q60 >> (60 - FRAC_BITS));
	localparam logic signed [W-1:0] HALF_PI_F  = W'(gcd_pkg::PI_Q60 >> (61 - FRAC_BITS));
	localparam logic signed [W-1:0] TWO_PI_F   = PI_F + PI_F;
	localparam logic signed [W-1:0] INV_GAIN_F = W'(gcd_pkg::INV_GAIN_Q60 >> (60 - FRAC_BITS));
	localparam logic [FRAC_BITS:0]  ONE_U      = {1'b1, {FRAC_BITS{1'b0}}};
	localparam logic signed [W:0]   ONE_S      = $signed({{4{1'b0}}, ONE_U});

	function automatic logic signed [W-1:0] mulf(input logic signed [W-1:0] a,
			input logic signed [W-1:0] b);
		logic [W-1:0] ma;
		logic [W-1:0] mb;
		logic [2*W-1:0] p;
		logic [W-1:0] r;
		ma = a[W-1] ? W'(-a) : W'(a);
		mb = b[W-1] ? W'(-b) : W'(b);
		p = (2*W)'(ma) * (2*W)'(mb);
		r = W'(p >> FRAC_BITS);
		return (a[W-1] ^ b[W-1]) ? -$signed(r) : $signed(r);
	endfunction

	logic            adv;
	logic [NST-1:0]  vld_q;
	logic [NST-1:0]  nf_q;
	logic [34:0]     rk_q;
	logic [15:0]     age_q;

	assign adv      = !vld_q[NST-1] || m_tready;
	assign s_tready = adv;
	assign m_tvalid = vld_q[NST-1];
	assign m_tuser  = nf_q[NST-1];

	// Configuration: the radius is kept premultiplied by the meters-per-kilofoot numerator.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rk_q  <= gcd_pkg::RADIUS_K_RESET;
			age_q <= gcd_pkg::AGE_RESET;
		end else if (wr_en) begin
			case (wr_index)
				gcd_pkg::CFG_RADIUS: rk_q <= 35'(wr_data) * 35'(gcd_pkg::M_PER_KFT_NUM);
				gcd_pkg::CFG_MAX_AGE: age_q <= wr_data[15:0];
				default: ;
			endcase
		end
	end

	// Input unpacking and fix check.
	logic signed [27:0] l_lat;
	logic signed [28:0] l_lon;
	logic [15:0]        l_age;
	logic signed [27:0] r_lat;
	logic signed [28:0] r_lon;
	logic               nofix;
	logic signed [29:0] ang [4];

	assign l_lat = s_tdata[27:0];
	assign l_lon = s_tdata[56:28];
	assign l_age = s_tdata[72:57];
	assign r_lat = s_tdata[100:73];
	assign r_lon = s_tdata[129:101];
	assign nofix = (l_lat == 28'sd0) || (l_lon == 29'sd0) || (l_age > age_q) ||
		(r_lat == 28'sd0) || (r_lon == 29'sd0);

	assign ang[0] = 30'(r_lat) - 30'(l_lat);
	assign ang[1] = 30'(r_lon) - 30'(l_lon);
	assign ang[2] = 30'(l_lat);
	assign ang[3] = 30'(r_lat);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_q <= '0;
		else if (adv)
			vld_q <= {vld_q[NST-2:0], s_tvalid};
	end

	always_ff @(posedge clk) begin
		if (adv)
			nf_q <= {nf_q[NST-2:0], nofix};
	end

	// Angle conversion, wrap and quadrant fold, then the sin/cos CORDIC lanes.
	logic [29:0]        mag_s1 [4];
	logic               sg_s1  [4];
	logic [61:0]        plo_s2 [4];
	logic [36:0]        phi_s2 [4];
	logic               sg_s2  [4];
	logic signed [W-1:0] th_s3 [4];
	logic signed [W-1:0] th_s4 [4];
	logic signed [W-1:0] cx [4][CORDIC_STEPS+1];
	logic signed [W-1:0] cy [4][CORDIC_STEPS+1];
	logic signed [W-1:0] cz [4][CORDIC_STEPS+1];
	logic                cn [4][CORDIC_STEPS+1];

	for (genvar j = 0; j < 4; j++) begin : g_conv
		// The two difference angles are halved.
		localparam int SH = 64 - FRAC_BITS + ((j < 2) ? 1 : 0);
		logic [68:0]  full;
		logic [W-1:0] rm;

		assign full = {phi_s2[j], 32'd0} + 69'(plo_s2[j]);
		assign rm   = W'(full >> SH);

		always_ff @(posedge clk) begin
			if (adv) begin
				sg_s1[j]  <= ang[j][29];
				mag_s1[j] <= ang[j][29] ? 30'(-ang[j]) : 30'(ang[j]);
				plo_s2[j] <= 62'(mag_s1[j]) * 62'(gcd_pkg::RAD_K[31:0]);
				phi_s2[j] <= 37'(mag_s1[j]) * 37'(gcd_pkg::RAD_K[38:32]);
				sg_s2[j]  <= sg_s1[j];
				th_s3[j]  <= sg_s2[j] ? -$signed(rm) : $signed(rm);
				if (th_s3[j] > PI_F)
					th_s4[j] <= th_s3[j] - TWO_PI_F;
				else if (th_s3[j] < -PI_F)
					th_s4[j] <= th_s3[j] + TWO_PI_F;
				else
					th_s4[j] <= th_s3[j];
				cx[j][0] <= INV_GAIN_F;
				cy[j][0] <= '0;
				if (th_s4[j] > HALF_PI_F) begin
					cz[j][0] <= th_s4[j] - PI_F;
					cn[j][0] <= 1'b1;
				end else if (th_s4[j] < -HALF_PI_F) begin
					cz[j][0] <= th_s4[j] + PI_F;
					cn[j][0] <= 1'b1;
				end else begin
					cz[j][0] <= th_s4[j];
					cn[j][0] <= 1'b0;
				end
			end
		end
	end

	// Haversine term.
	logic signed [W-1:0] hv_sl_s1, hv_so_s1, hv_c1_s1, hv_c2_s1;
	logic signed [W-1:0] hv_p1_s2, hv_p2_s2, hv_p3_s2;
	logic signed [W-1:0] hv_p1_s3, hv_p4_s3;
	logic signed [W:0]   asum;
	logic [FRAC_BITS:0]  ac;
	logic [gcd_pkg::ISQ_W-1:0] qv [2][gcd_pkg::ISQ_STEPS+1];
	logic [gcd_pkg::ISQ_W-1:0] qr [2][gcd_pkg::ISQ_STEPS+1];

	assign asum = (W+1)'(hv_p1_s3) + (W+1)'(hv_p4_s3);
	always_comb begin
		if (asum < 0)
			ac = '0;
		else if (asum > ONE_S)
			ac = ONE_U;
		else
			ac = (FRAC_BITS+1)'(asum);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			hv_sl_s1 <= cn[0][CORDIC_STEPS] ? -cy[0][CORDIC_STEPS] : cy[0][CORDIC_STEPS];
			hv_so_s1 <= cn[1][CORDIC_STEPS] ? -cy[1][CORDIC_STEPS] : cy[1][CORDIC_STEPS];
			hv_c1_s1 <= cn[2][CORDIC_STEPS] ? -cx[2][CORDIC_STEPS] : cx[2][CORDIC_STEPS];
			hv_c2_s1 <= cn[3][CORDIC_STEPS] ? -cx[3][CORDIC_STEPS] : cx[3][CORDIC_STEPS];
			hv_p1_s2 <= mulf(hv_sl_s1, hv_sl_s1);
			hv_p2_s2 <= mulf(hv_c1_s1, hv_c2_s1);
			hv_p3_s2 <= mulf(hv_so_s1, hv_so_s1);
			hv_p1_s3 <= hv_p1_s2;
			hv_p4_s3 <= mulf(hv_p2_s2, hv_p3_s2);
			// Lane 0 takes sqrt(a), lane 1 sqrt(1 - a), both as Q62 radicands.
			qv[0][0] <= gcd_pkg::ISQ_W'(ac) << (62 - FRAC_BITS);
			qv[1][0] <= gcd_pkg::ISQ_W'(ONE_U - ac) << (62 - FRAC_BITS);
			qr[0][0] <= '0;
			qr[1][0] <= '0;
		end
	end

	// Integer square root, one result bit and two radicand bits per stage.
	for (genvar k = 0; k < gcd_pkg::ISQ_STEPS; k++) begin : g_isq
		localparam logic [gcd_pkg::ISQ_W-1:0] BITK = 63'd1 << (62 - 2 * k);
		for (genvar l = 0; l < 2; l++) begin : g_lane
			logic [gcd_pkg::ISQ_W-1:0] t;
			assign t = qr[l][k] + BITK;
			always_ff @(posedge clk) begin
				if (adv) begin
					if (qv[l][k] >= t) begin
						qv[l][k+1] <= qv[l][k] - t;
						qr[l][k+1] <= (qr[l][k] >> 1) + BITK;
					end else begin
						qv[l][k+1] <= qv[l][k];
						qr[l][k+1] <= qr[l][k] >> 1;
					end
				end
			end
		end
	end

	// CORDIC stages: rotation for sin/cos, vectoring for atan2.
	logic signed [XW-1:0] ax [CORDIC_STEPS];
	logic signed [XW-1:0] ay [CORDIC_STEPS];
	logic signed [W-1:0]  az [CORDIC_STEPS];

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
		localparam logic signed [W-1:0] ATN = W'(gcd_pkg::atan_q60(i) >> (60 - FRAC_BITS));
		logic signed [XW-1:0] xi, yi;
		logic signed [W-1:0]  zi;

		for (genvar j = 0; j < 4; j++) begin : g_rot
			always_ff @(posedge clk) begin
				if (adv) begin
					if (!cz[j][i][W-1]) begin
						cx[j][i+1] <= cx[j][i] - (cy[j][i] >>> i);
						cy[j][i+1] <= cy[j][i] + (cx[j][i] >>> i);
						cz[j][i+1] <= cz[j][i] - ATN;
					end else begin
						cx[j][i+1] <= cx[j][i] + (cy[j][i] >>> i);
						cy[j][i+1] <= cy[j][i] - (cx[j][i] >>> i);
						cz[j][i+1] <= cz[j][i] + ATN;
					end
					cn[j][i+1] <= cn[j][i];
				end
			end
		end

		if (i == 0) begin : g_first
			assign xi = $signed(XW'(qr[1][gcd_pkg::ISQ_STEPS]));
			assign yi = $signed(XW'(qr[0][gcd_pkg::ISQ_STEPS]));
			assign zi = '0;
		end else begin : g_next
			assign xi = ax[i-1];
			assign yi = ay[i-1];
			assign zi = az[i-1];
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				if (!yi[XW-1]) begin
					ax[i] <= xi + (yi >>> i);
					ay[i] <= yi - (xi >>> i);
					az[i] <= zi + ATN;
				end else begin
					ax[i] <= xi - (yi >>> i);
					ay[i] <= yi + (xi >>> i);
					az[i] <= zi - ATN;
				end
			end
		end
	end

	// Scale by radius and divide by 3281 through a reciprocal with one correction.
	logic [W-1:0]   zc;
	logic [Z2W-1:0] z2;
	logic [17+Z2W:0] fd_plo_s1;
	logic [16+Z2W:0] fd_phi_s1;
	logic [34+Z2W:0] prod;
	logic [gcd_pkg::Q_W-1:0] fd_q_s2, fd_q_s3, fd_q_s4;
	logic [55:0]    fd_ra_s3;
	logic [54:0]    fd_rb_s3;
	logic [73:0]    rsum;
	logic [gcd_pkg::EST_W-1:0] fd_est_s4;
	logic [gcd_pkg::Q_W-1:0]   rem;
	logic [gcd_pkg::EST_W-1:0] est_fix;
	logic [gcd_pkg::DIST_W-1:0] dist_s5;

	assign zc   = az[CORDIC_STEPS-1][W-1] ? '0 : az[CORDIC_STEPS-1];
	assign z2   = Z2W'(zc) << 1;
	assign prod = {fd_phi_s1, 18'd0} + (35+Z2W)'(fd_plo_s1);
	assign rsum = {fd_rb_s3, 19'd0} + 74'(fd_ra_s3);
	assign rem  = fd_q_s4 - gcd_pkg::Q_W'(37'(fd_est_s4) * 37'(gcd_pkg::M_PER_KFT_DEN));
	assign est_fix = (rem >= gcd_pkg::Q_W'(gcd_pkg::M_PER_KFT_DEN)) ?
		fd_est_s4 + 26'd1 : fd_est_s4;

	always_ff @(posedge clk) begin
		if (adv) begin
			fd_plo_s1 <= (18+Z2W)'(rk_q[17:0]) * (18+Z2W)'(z2);
			fd_phi_s1 <= (17+Z2W)'(rk_q[34:18]) * (17+Z2W)'(z2);
			fd_q_s2   <= gcd_pkg::Q_W'(prod >> FRAC_BITS);
			fd_ra_s3  <= 56'(fd_q_s2[18:0]) * 56'(gcd_pkg::RECIP_M);
			fd_rb_s3  <= 55'(fd_q_s2[36:19]) * 55'(gcd_pkg::RECIP_M);
			fd_q_s3   <= fd_q_s2;
			fd_est_s4 <= gcd_pkg::EST_W'(rsum >> gcd_pkg::RECIP_S);
			fd_q_s4   <= fd_q_s3;
			dist_s5   <= nf_q[NST-2] ? '0 : gcd_pkg::DIST_W'(est_fix);
		end
	end

	assign m_tdata = {{(gcd_pkg::OUT_W - gcd_pkg::DIST_W){1'b0}}, dist_s5};

endmodule

[rtl/gcd_checker.sv]
module gcd_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      s_tvalid,
	input logic                      s_tready,
	input logic                      m_tvalid,
	input logic                      m_tready,
	input logic [gcd_pkg::OUT_W-1:0] m_tdata,
	input logic                      m_tuser
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("output beat changed while stalled");

	// A beat without a usable fix reports zero distance.
	a_nofix_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata == '0)
		else $error("no-fix beat with nonzero distance");

	// The pipeline stalls as a whole, so a held output blocks the input.
	a_stall_in: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |-> !s_tready)
		else $error("input taken while output stalled");

	a_flow: assert property (@(posedge clk) disable iff (!arst_n)
		m_tready |-> s_tready)
		else $error("input blocked although output is ready");

endmodule

bind great_circle_distance gcd_checker u_gcd_checker (.*);

[dv/tb_great_circle_distance.sv]
`timescale 1ns / 1ps

module tb_great_circle_distance;

	localparam int STEPS = 32;
	localparam int FB    = 30;
	localparam int PIPE_DEPTH = 2 * STEPS + 46;

	// Last member sits in the lowest bits, matching the s_tdata field order.
	typedef struct packed {
		logic signed [28:0] lon2;
		logic signed [27:0] lat2;
		logic [15:0]        age;
		logic signed [28:0] lon1;
		logic signed [27:0] lat1;
	} fix_pair_t;

	typedef struct packed {
		logic        no_fix;
		logic [24:0] dist_m;
	} range_t;

	logic clk, arst_n;
	logic s_tvalid, s_tready, m_tvalid, m_tready, m_tuser;
	logic [gcd_pkg::IN_W-1:0] s_tdata;
	logic [gcd_pkg::OUT_W-1:0] m_tdata;
	logic wr_en;
	logic [0:0] wr_index;
	logic [24:0] wr_data;

	great_circle_distance DUT (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// Predictor state: its own copy of the registers and the arctangent table.
	logic [24:0] radius_ft;
	logic [15:0] age_limit;
	longint atan_q[STEPS];

	fix_pair_t pending_pairs[$];
	range_t    expected_ranges[$];
	int errors = 0;
	int checked = 0;
	int no_fix_seen = 0;
	bit stall_start = 0;
	bit long_stall = 0;

	function automatic longint shr_floor(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint q_mul(longint a, longint b);
		logic signed [127:0] p;
		logic [127:0] m;
		p = 128'(a) * 128'(b);
		m = p < 0 ? -p : p;
		m = m >> FB;
		return p < 0 ? -longint'(m) : longint'(m);
	endfunction

	function automatic longint udeg_rad(longint udeg, int extra);
		logic [127:0] m;
		m = 128'(udeg < 0 ? -udeg : udeg) * 128'(gcd_pkg::RAD_K);
		m = m >> (64 - FB + extra);
		return udeg < 0 ? -longint'(m) : longint'(m);
	endfunction

	function automatic void rotate_sincos(input longint th, output longint s,
			output longint c);
		longint pi_q, half_pi, x, y, nx;
		bit flip;
		pi_q = longint'(gcd_pkg::PI_Q60 >> (60 - FB));
		half_pi = longint'(gcd_pkg::PI_Q60 >> (61 - FB));
		x = longint'(gcd_pkg::INV_GAIN_Q60 >> (60 - FB));
		y = 0;
		flip = 0;
		while (th > pi_q) th -= 2 * pi_q;
		while (th < -pi_q) th += 2 * pi_q;
		if (th > half_pi) begin
			th -= pi_q;
			flip = 1;
		end else if (th < -half_pi) begin
			th += pi_q;
			flip = 1;
		end
		for (int i = 0; i < STEPS; i++) begin
			if (th >= 0) begin
				nx = x - shr_floor(y, i); y = y + shr_floor(x, i); th -= atan_q[i];
			end else begin
				nx = x + shr_floor(y, i); y = y - shr_floor(x, i); th += atan_q[i];
			end
			x = nx;
		end
		s = flip ? -y : y;
		c = flip ? -x : x;
	endfunction

	function automatic longint int_sqrt(logic [63:0] v);
		logic [63:0] res, b;
		res = 0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return longint'(res);
	endfunction

	function automatic range_t predict_range(fix_pair_t p);
		range_t r;
		longint sl, cl, so, co, s1, c1, s2, c2, a, x, y, z, nx, one;
		logic [127:0] prod;
		one = longint'(1) << FB;
		r.no_fix = 1'b1;
		r.dist_m = '0;
		if (p.lat1 == 0 || p.lon1 == 0 || p.age > age_limit || p.lat2 == 0 || p.lon2 == 0)
			return r;
		rotate_sincos(udeg_rad(longint'(p.lat2) - longint'(p.lat1), 1), sl, cl);
		rotate_sincos(udeg_rad(longint'(p.lon2) - longint'(p.lon1), 1), so, co);
		rotate_sincos(udeg_rad(longint'(p.lat1), 0), s1, c1);
		rotate_sincos(udeg_rad(longint'(p.lat2), 0), s2, c2);
		a = q_mul(sl, sl) + q_mul(q_mul(c1, c2), q_mul(so, so));
		if (a < 0) a = 0;
		if (a > one) a = one;
		y = int_sqrt(64'(a) << (62 - FB));
		x = int_sqrt(64'(one - a) << (62 - FB));
		z = 0;
		for (int i = 0; i < STEPS; i++) begin
			if (y >= 0) begin
				nx = x + shr_floor(y, i); y = y - shr_floor(x, i); z += atan_q[i];
			end else begin
				nx = x - shr_floor(y, i); y = y + shr_floor(x, i); z -= atan_q[i];
			end
			x = nx;
		end
		if (z < 0) z = 0;
		prod = 128'(64'(radius_ft) * 64'd1000) * 128'(2 * z);
		prod = (prod >> FB) / 128'd3281;
		r.no_fix = 1'b0;
		r.dist_m = prod[24:0];
		return r;
	endfunction

	function automatic fix_pair_t rand_pair(bit near);
		fix_pair_t p;
		p.lat1 = 28'($signed($urandom_range(180000000)) - 90000000);
		p.lon1 = 29'($signed($urandom_range(360000000)) - 180000000);
		if (near) begin
			p.lat2 = 28'(p.lat1 + $signed($urandom_range(20000)) - 10000);
			p.lon2 = 29'(p.lon1 + $signed($urandom_range(20000)) - 10000);
		end else begin
			p.lat2 = 28'($signed($urandom_range(180000000)) - 90000000);
			p.lon2 = 29'($signed($urandom_range(360000000)) - 180000000);
		end
		p.age = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(age_limit));
		if ($urandom_range(29) == 0) p.lat1 = 28'($urandom);
		if ($urandom_range(29) == 0) p.lon2 = 29'($urandom);
		if ($urandom_range(39) == 0) p.lon1 = '0;
		if ($urandom_range(39) == 0) p.lat2 = '0;
		return p;
	endfunction

	// Driver: one pending pair per beat, at times back to back, else after a random gap.
	int send_gap = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			send_gap <= 0;
		end else if (s_tvalid && !s_tready) begin
			// Hold the offered beat.
		end else if (s_tvalid && s_tready) begin
			expected_ranges.push_back(predict_range(s_tdata[$bits(fix_pair_t)-1:0]));
			if (pending_pairs.size() > 0 && $urandom_range(2) == 0) begin
				s_tdata <= gcd_pkg::IN_W'(pending_pairs.pop_front());
			end else begin
				s_tvalid <= 1'b0;
				send_gap <= $urandom_range(14);
			end
		end else if (send_gap > 0) begin
			send_gap <= send_gap - 1;
		end else if (pending_pairs.size() > 0) begin
			s_tvalid <= 1'b1;
			s_tdata <= gcd_pkg::IN_W'(pending_pairs.pop_front());
		end
	end

	// The long receiver stall is timed here, apart from the monitor.
	initial begin
		wait (stall_start);
		long_stall = 1'b1;
		repeat (400) @(posedge clk);
		long_stall = 1'b0;
	end

	// Monitor: compares every output beat with the oldest prediction.
	int recv_gap = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			recv_gap <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (expected_ranges.size() == 0) begin
					$display("%t: unexpected beat tuser=%0d tdata=%0d", $realtime, m_tuser,
						m_tdata);
					errors++;
				end else begin
					range_t e;
					e = expected_ranges.pop_front();
					if (m_tuser !== e.no_fix || m_tdata !== gcd_pkg::OUT_W'(e.dist_m)) begin
						$display("%t: expected status=%0d dist=%0d, got status=%0d dist=%0d",
							$realtime, e.no_fix, e.dist_m, m_tuser, m_tdata);
						errors++;
					end
					checked++;
					if (e.no_fix) no_fix_seen++;
				end
			end
			if (long_stall) begin
				m_tready <= 1'b0;
			end else if (m_tvalid && m_tready || recv_gap == 0) begin
				if (m_tvalid && m_tready && $urandom_range(2) == 0) begin
					m_tready <= 1'b0;
					recv_gap <= $urandom_range(14);
				end else begin
					m_tready <= 1'b1;
				end
			end else begin
				recv_gap <= recv_gap - 1;
				m_tready <= (recv_gap == 1);
			end
		end
	end

	task automatic drain;
		while (pending_pairs.size() > 0 || s_tvalid || expected_ranges.size() > 0)
			@(posedge clk);
		repeat (PIPE_DEPTH + 10) @(posedge clk);
	endtask

	task automatic write_reg(input logic [0:0] idx, input logic [24:0] val);
		@(posedge clk);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= val;
		@(posedge clk);
		wr_en <= 1'b0;
		if (idx == gcd_pkg::CFG_RADIUS) radius_ft = val;
		else age_limit = val[15:0];
	endtask

	function automatic fix_pair_t mk(int la1, int lo1, int ag, int la2, int lo2);
		fix_pair_t p;
		p.lat1 = 28'(la1); p.lon1 = 29'(lo1); p.age = 16'(ag);
		p.lat2 = 28'(la2); p.lon2 = 29'(lo2);
		return p;
	endfunction

	initial begin
		logic [24:0] radii[4];
		logic [15:0] limits[4];
		radii = '{25'd20902231, 25'd1, 25'h1FFFFFF, 25'd0};
		limits = '{16'd5000, 16'd0, 16'hFFFF, 16'd123};
		for (int i = 0; i < STEPS; i++)
			atan_q[i] = longint'(gcd_pkg::atan_q60(i)) >>> (60 - FB);
		radius_ft = gcd_pkg::RADIUS_RESET;
		age_limit = gcd_pkg::AGE_RESET;
		arst_n = 1'b0;
		wr_en = 1'b0;
		wr_index = '0;
		wr_data = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: field extremes, the no-fix conditions and angle wrapping.
		pending_pairs.push_back(mk(90000000, 180000000, 0, -90000000, -180000000));
		pending_pairs.push_back(mk(-90000000, -180000000, 5000, 90000000, 180000000));
		pending_pairs.push_back(mk(1, 1, 0, 1, 1));
		pending_pairs.push_back(mk(45000000, 179999999, 10, 45000000, -179999999));
		pending_pairs.push_back(mk(0, 5, 0, 5, 5));
		pending_pairs.push_back(mk(5, 0, 0, 5, 5));
		pending_pairs.push_back(mk(5, 5, 0, 0, 5));
		pending_pairs.push_back(mk(5, 5, 0, 5, 0));
		pending_pairs.push_back(mk(5, 5, 5001, 5, 5));
		pending_pairs.push_back(mk(5, 5, 65535, 5, 5));
		pending_pairs.push_back(mk(10000000, 20000000, 1, -10000000, -160000000));
		pending_pairs.push_back(mk(-134217728, -268435456, 3, 134217727, 268435455));
		pending_pairs.push_back(mk(51500000, -120000, 100, 40700000, -74000000));
		pending_pairs.push_back(mk(-33900000, 151200000, 100, 33900000, -28800000));
		pending_pairs.push_back(mk(12345678, 87654321, 0, 12345678, 87654321));
		drain();

		for (int ph = 0; ph < 4; ph++) begin
			write_reg(gcd_pkg::CFG_RADIUS, radii[ph]);
			write_reg(gcd_pkg::CFG_MAX_AGE, 25'(limits[ph]));
			for (int n = 0; n < 500; n++) pending_pairs.push_back(rand_pair($urandom_range(3) == 0));
			if (ph == 1) begin
				// Long receiver stall while the sender keeps offering beats.
				repeat (20) @(posedge clk);
				stall_start = 1'b1;
			end
			drain();
		end
		$display("Checked %0d result beats, %0d of them flagged as no fix,", checked, no_fix_seen);
		$display("over four radius and age-limit settings including the extremes.");
		if (errors == 0)
			$display("tb_great_circle_distance OK");
		else
			$display("tb_great_circle_distance NOT OK");
		$finish;
	end

	initial begin
		#5ms;
		$display("Timeout with %0d beats outstanding", expected_ranges.size());
		$display("tb_great_circle_distance NOT OK");
		$finish;
	end

endmodule

[sim.f]
rtl/gcd_pkg.sv
rtl/great_circle_distance.sv
rtl/gcd_checker.sv
dv/tb_great_circle_distance.sv
